/* hdl/ksa_pkg.sv */
// Shared types and constants for the scan-code set 1 keyboard decoder.
// Holds the key layout lookup, command codes and the result beat struct.
// No dependencies.
`timescale 1ns / 1ps

package ksa_pkg;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_IDLE = 1'b1;

  // Result destinations
  localparam logic DEST_CHAR = 1'b0;
  localparam logic DEST_KBD  = 1'b1;

  // Keyboard commands and responses
  localparam logic [7:0] LED_CMD     = 8'hED;
  localparam logic [7:0] KBD_ACK     = 8'hFA;
  localparam logic [7:0] KBD_RESEND  = 8'hFE;
  localparam logic [7:0] RESEND_NONE = 8'hFF;

  // Scan codes with side effects
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_LOCK    = 8'h3A;
  localparam logic [7:0] SC_NUM_LOCK     = 8'h45;
  localparam logic [7:0] SC_SCROLL_LOCK  = 8'h46;

  // LED bit masks
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic       destination;
    logic [7:0] value;
    logic       last;
  } result_t;

  // Layout lookup for make codes below 0x80; zero means no character.
  function automatic logic [7:0] key_char(input logic [6:0] code, input logic shifted);
    logic [7:0] ch;
    ch = 8'h00;
    case (code)
      7'h02: ch = shifted ? 8'h21 : 8'h31;
      7'h03: ch = shifted ? 8'h22 : 8'h32;
      7'h04: ch = shifted ? 8'h23 : 8'h33;
      7'h05: ch = shifted ? 8'h24 : 8'h34;
      7'h06: ch = shifted ? 8'h25 : 8'h35;
      7'h07: ch = shifted ? 8'h26 : 8'h36;
      7'h08: ch = shifted ? 8'h27 : 8'h37;
      7'h09: ch = shifted ? 8'h28 : 8'h38;
      7'h0A: ch = shifted ? 8'h29 : 8'h39;
      7'h0B: ch = shifted ? 8'h7E : 8'h30;
      7'h0C: ch = shifted ? 8'h3D : 8'h2D;
      7'h0D: ch = shifted ? 8'h7E : 8'h5E;
      7'h0E: ch = 8'h08;
      7'h10: ch = 8'h51;
      7'h11: ch = 8'h57;
      7'h12: ch = 8'h45;
      7'h13: ch = 8'h52;
      7'h14: ch = 8'h54;
      7'h15: ch = 8'h59;
      7'h16: ch = 8'h55;
      7'h17: ch = 8'h49;
      7'h18: ch = 8'h4F;
      7'h19: ch = 8'h50;
      7'h1A: ch = shifted ? 8'h60 : 8'h40;
      7'h1B: ch = shifted ? 8'h7B : 8'h5B;
      7'h1C: ch = 8'h0A;
      7'h1E: ch = 8'h41;
      7'h1F: ch = 8'h53;
      7'h20: ch = 8'h44;
      7'h21: ch = 8'h46;
      7'h22: ch = 8'h47;
      7'h23: ch = 8'h48;
      7'h24: ch = 8'h4A;
      7'h25: ch = 8'h4B;
      7'h26: ch = 8'h4C;
      7'h27: ch = shifted ? 8'h2B : 8'h3B;
      7'h28: ch = shifted ? 8'h2A : 8'h3A;
      7'h2B: ch = shifted ? 8'h7D : 8'h5D;
      7'h2C: ch = 8'h5A;
      7'h2D: ch = 8'h58;
      7'h2E: ch = 8'h43;
      7'h2F: ch = 8'h56;
      7'h30: ch = 8'h42;
      7'h31: ch = 8'h4E;
      7'h32: ch = 8'h4D;
      7'h33: ch = shifted ? 8'h3C : 8'h2C;
      7'h34: ch = shifted ? 8'h3E : 8'h2E;
      7'h35: ch = shifted ? 8'h3F : 8'h2F;
      7'h37: ch = 8'h2A;
      7'h39: ch = 8'h20;
      7'h47: ch = 8'h37;
      7'h48: ch = 8'h38;
      7'h49: ch = 8'h39;
      7'h4A: ch = 8'h2D;
      7'h4B: ch = 8'h34;
      7'h4C: ch = 8'h35;
      7'h4D: ch = 8'h36;
      7'h4E: ch = 8'h2B;
      7'h4F: ch = 8'h31;
      7'h50: ch = 8'h32;
      7'h51: ch = 8'h33;
      7'h52: ch = 8'h30;
      7'h53: ch = 8'h2E;
      7'h73: ch = shifted ? 8'h5F : 8'h5C;
      7'h7D: ch = shifted ? 8'h7C : 8'h5C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hdl/keyboard_scancode_to_ascii.sv */
// Top level of the scan-code set 1 keyboard decoder with command queue.
// Depends on ksa_pkg for the layout lookup, codes and result struct.
`timescale 1ns / 1ps

// Usage
// Input channel (item_valid / item_stall): one beat per keyboard byte or idle
//   tick. Every beat first offers one send slot for the keyboard command
//   queue; keyboard bytes are then decoded to ASCII or drive shift, lock,
//   acknowledge and resend handling.
// Result channel (result_valid / result_stall): zero to two beats per input
//   beat, in order; last marks the final beat of an input beat.
// Each input beat is registered, and its results go to the result buffer.
// Throughput: one input beat a cycle while each gives at most one result
//   and the receiver does not stall. A lock key holds the next beat, since
//   the command queue RAM takes one write a cycle and a lock key queues two
//   bytes. Items with two results are paced by the result port.
// A four-beat result buffer lets input beats flow while a result waits;
//   when the receiver stalls, the buffer fills and item_stall rises.
// Reset: shift and lock state clear, the queue holds the LED command and a
//   zero LED byte, nothing awaits acknowledge. No clearing pass is needed.
module keyboard_scancode_to_ascii #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       operation,
  input  logic [7:0] scan_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       destination,
  output logic [7:0] value,
  output logic       last
);
  import ksa_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_POS  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);

  // Input register
  logic       in_full;
  logic       op_q;
  logic [7:0] code_q;

  // Decoder state
  logic [1:0]    shift_keys, shift_keys_next;
  logic [2:0]    lock_leds, lock_leds_next;
  logic [AW-1:0] rd_pos, rd_pos_next;
  logic [CW-1:0] q_count, q_count_next;
  logic          awaiting_ack, awaiting_ack_next;
  logic [7:0]    pending_byte, pending_byte_next;

  // Deferred second queue write
  logic          wr2_pending, wr2_pending_next;
  logic [AW-1:0] wr2_addr, wr2_addr_next;
  logic [7:0]    wr2_data, wr2_data_next;

  // Queue RAM and head read
  logic [7:0]    queue_mem [QUEUE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [1:0]    boot_entry;
  logic [7:0]    head_raw;
  logic          head_alt_sel;
  logic [7:0]    head_alt;
  logic [7:0]    head_byte;

  // Result buffer
  result_t    obuf [4];
  logic [1:0] owp, orp;
  logic [2:0] ocnt;
  logic       pop;

  logic       fire;
  logic [1:0] n_res;
  result_t    res [2];
  logic [7:0] ch;

  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] tail_pos(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= DEPTH_SUM) begin
      s = s - DEPTH_SUM;
    end
    return s[AW-1:0];
  endfunction

  assign head_byte    = head_alt_sel ? head_alt : head_raw;
  assign fire         = in_full && !wr2_pending && (ocnt <= 3'd2);
  assign item_stall   = in_full && !fire;
  assign result_valid = (ocnt != 3'd0);
  assign pop          = result_valid && !result_stall;
  assign destination  = obuf[orp].destination;
  assign value        = obuf[orp].value;
  assign last         = obuf[orp].last;

  always_comb begin
    shift_keys_next   = shift_keys;
    lock_leds_next    = lock_leds;
    rd_pos_next       = rd_pos;
    q_count_next      = q_count;
    awaiting_ack_next = awaiting_ack;
    pending_byte_next = pending_byte;
    wr2_pending_next  = 1'b0;
    wr2_addr_next     = wr2_addr;
    wr2_data_next     = wr2_data;
    wr_en             = wr2_pending;
    wr_addr           = wr2_addr;
    wr_data           = wr2_data;
    n_res             = 2'd0;
    res[0]            = '0;
    res[1]            = '0;
    ch                = 8'h00;

    if (fire) begin
      // Send slot: pop the queue head if the queue is not empty and no acknowledge is outstanding
      if (q_count != '0 && !awaiting_ack) begin
        rd_pos_next       = pos_inc(rd_pos);
        q_count_next      = q_count - CW'(1);
        awaiting_ack_next = 1'b1;
        pending_byte_next = head_byte;
        res[0]            = '{destination: DEST_KBD, value: head_byte, last: 1'b0};
        n_res             = 2'd1;
      end

      if (op_q == OP_BYTE) begin
        if (!code_q[7]) begin
          ch = key_char(code_q[6:0], shift_keys != 2'b00);
        end
        // Lower-case letters unless exactly one of shift and caps lock applies
        if (ch >= 8'h41 && ch <= 8'h5A) begin
          if (((lock_leds & LED_CAPS) != 3'b000) == (shift_keys != 2'b00)) begin
            ch = ch + CASE_OFFSET;
          end
        end
        if (ch != 8'h00) begin
          res[n_res[0]] = '{destination: DEST_CHAR, value: ch, last: 1'b0};
          n_res         = n_res + 2'd1;
        end

        case (code_q)
          SC_LSHIFT_MAKE:  shift_keys_next = shift_keys | 2'b01;
          SC_RSHIFT_MAKE:  shift_keys_next = shift_keys | 2'b10;
          SC_LSHIFT_BREAK: shift_keys_next = shift_keys & 2'b10;
          SC_RSHIFT_BREAK: shift_keys_next = shift_keys & 2'b01;
          SC_CAPS_LOCK, SC_NUM_LOCK, SC_SCROLL_LOCK: begin
            if (code_q == SC_CAPS_LOCK) begin
              lock_leds_next = lock_leds ^ LED_CAPS;
            end else if (code_q == SC_NUM_LOCK) begin
              lock_leds_next = lock_leds ^ LED_NUM;
            end else begin
              lock_leds_next = lock_leds ^ LED_SCROLL;
            end
            // Queue LED command now, the LED byte on the following cycle
            if (q_count_next < DEPTH_CNT) begin
              wr_en        = 1'b1;
              wr_addr      = tail_pos(rd_pos_next, q_count_next);
              wr_data      = LED_CMD;
              q_count_next = q_count_next + CW'(1);
            end
            if (q_count_next < DEPTH_CNT) begin
              wr2_pending_next = 1'b1;
              wr2_addr_next    = tail_pos(rd_pos_next, q_count_next);
              wr2_data_next    = {5'b00000, lock_leds_next};
              q_count_next     = q_count_next + CW'(1);
            end
          end
          KBD_ACK: awaiting_ack_next = 1'b0;
          KBD_RESEND: begin
            res[n_res[0]] = '{destination: DEST_KBD,
                              value: awaiting_ack_next ? pending_byte_next : RESEND_NONE,
                              last: 1'b0};
            n_res         = n_res + 2'd1;
          end
          default: ;
        endcase
      end

      if (n_res == 2'd1) begin
        res[0].last = 1'b1;
      end else if (n_res == 2'd2) begin
        res[1].last = 1'b1;
      end
    end
  end

  // Queue RAM: one write port, registered read of the next head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_addr] <= wr_data;
    end
    head_raw <= queue_mem[rd_pos_next];
  end

  // Bypass for a same-cycle write to the head and for the two reset entries
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_entry   <= 2'b11;
      head_alt_sel <= 1'b1;
      head_alt     <= LED_CMD;
    end else begin
      if (wr_en && wr_addr == AW'(0)) begin
        boot_entry[0] <= 1'b0;
      end
      if (wr_en && wr_addr == AW'(1)) begin
        boot_entry[1] <= 1'b0;
      end
      if (wr_en && wr_addr == rd_pos_next) begin
        head_alt_sel <= 1'b1;
        head_alt     <= wr_data;
      end else if (rd_pos_next == AW'(0) && boot_entry[0]) begin
        head_alt_sel <= 1'b1;
        head_alt     <= LED_CMD;
      end else if (rd_pos_next == AW'(1) && boot_entry[1]) begin
        head_alt_sel <= 1'b1;
        head_alt     <= 8'h00;
      end else begin
        head_alt_sel <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      shift_keys   <= 2'b00;
      lock_leds    <= 3'b000;
      rd_pos       <= '0;
      q_count      <= CW'(2);
      awaiting_ack <= 1'b0;
      pending_byte <= 8'h00;
      wr2_pending  <= 1'b0;
      owp          <= 2'd0;
      orp          <= 2'd0;
      ocnt         <= 3'd0;
    end else begin
      if (item_valid && !item_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      shift_keys   <= shift_keys_next;
      lock_leds    <= lock_leds_next;
      rd_pos       <= rd_pos_next;
      q_count      <= q_count_next;
      awaiting_ack <= awaiting_ack_next;
      pending_byte <= pending_byte_next;
      wr2_pending  <= wr2_pending_next;
      owp          <= owp + n_res;
      if (pop) begin
        orp <= orp + 2'd1;
      end
      ocnt <= ocnt + {1'b0, n_res} - {2'b00, pop};
    end
  end

  // Payload registers: input beat, deferred write, result buffer
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      op_q   <= operation;
      code_q <= scan_code;
    end
    wr2_addr <= wr2_addr_next;
    wr2_data <= wr2_data_next;
    if (n_res != 2'd0) begin
      obuf[owp] <= res[0];
    end
    if (n_res == 2'd2) begin
      obuf[owp + 2'd1] <= res[1];
    end
  end

endmodule
